// File: sv/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared types, constants and functions
// Quaternion to Euler attitude: CORDIC lane type, arctangent table, scaling.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int CORDIC_STAGES = 30;
   localparam int STAGE_IDX_W   = 6;
   localparam int DATA_W        = 64;
   localparam int ANGLE_W       = 36;
   localparam int CHAIN_LAT     = CORDIC_STAGES + 1;
   localparam int TOTAL_LAT     = 2 + CHAIN_LAT + 2 + CHAIN_LAT;

   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q32  = 36'sd6746518852;
   localparam logic [31:0]               INV_GAIN_Q32 = 32'd2608131496;
   localparam logic signed [32:0]        ROLL_MAX     = 33'sd1686629714;
   localparam logic signed [32:0]        PITCH_MAX    = 33'sd843314857;

   typedef struct packed {
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  y;
      logic signed [ANGLE_W-1:0] z;
      logic                      zero;
   } cordic_lane_type;

   typedef struct packed {
      logic signed [31:0] yaw;
      logic signed [30:0] pitch;
      logic signed [31:0] roll;
   } rsp_word_type;

   // round(atan(2^-i) * 2^32), zero past stage 32
   function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [STAGE_IDX_W-1:0] i);
      logic signed [ANGLE_W-1:0] r;
      unique case (i)
         6'd0:    r = 36'sd3373259426;
         6'd1:    r = 36'sd1991351318;
         6'd2:    r = 36'sd1052175346;
         6'd3:    r = 36'sd534100635;
         6'd4:    r = 36'sd268086748;
         6'd5:    r = 36'sd134174063;
         6'd6:    r = 36'sd67103403;
         6'd7:    r = 36'sd33553749;
         6'd8:    r = 36'sd16777131;
         6'd9:    r = 36'sd8388597;
         6'd10:   r = 36'sd4194303;
         default: begin
            if (i <= 6'd32) r = $signed(36'd1 << (6'd32 - i));
            else r = '0;
         end
      endcase
      return r;
   endfunction

   // Q32 angle accumulator to Q3.29 with round and clamp
   function automatic logic signed [32:0] sat_angle(input logic signed [ANGLE_W-1:0] acc,
                                                    input logic signed [32:0] lim);
      logic signed [ANGLE_W-1:0] v;
      logic signed [ANGLE_W-1:0] lim_x;
      logic signed [32:0]        r;
      v     = (acc + 36'sd4) >>> 3;
      lim_x = ANGLE_W'(lim);
      if (v > lim_x)       r = lim;
      else if (v < -lim_x) r = -lim;
      else                 r = v[32:0];
      return r;
   endfunction

endpackage

// File: sv/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward the x axis by atan(2^-i) and registers the lane.
// ----------------------------------------------------------------------------
module qte_cordic_cell (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [qte_pkg::STAGE_IDX_W-1:0]    stage_idx,
   input  qte_pkg::cordic_lane_type           lane_i,
   output qte_pkg::cordic_lane_type           lane_o
);
   import qte_pkg::*;

   cordic_lane_type           lane_ff, lane_in;
   logic signed [DATA_W-1:0]  dx, dy;

   always_comb begin
      dx           = lane_i.x >>> stage_idx;
      dy           = lane_i.y >>> stage_idx;
      lane_in      = lane_i;
      if (!lane_i.y[DATA_W-1]) begin
         lane_in.x = lane_i.x + dy;
         lane_in.y = lane_i.y - dx;
         lane_in.z = lane_i.z + atan_step(stage_idx);
      end else begin
         lane_in.x = lane_i.x - dy;
         lane_in.y = lane_i.y + dx;
         lane_in.z = lane_i.z - atan_step(stage_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) lane_ff <= lane_in;
   end

   assign lane_o = lane_ff;

endmodule

// File: sv/qte_cordic_chain.sv
// ----------------------------------------------------------------------------
// qte_cordic_chain: pipelined vectoring atan2
// Quadrant pre-rotation register, then a row of CORDIC cells.
// ----------------------------------------------------------------------------
module qte_cordic_chain (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic signed [qte_pkg::DATA_W-1:0]    in_y,
   input  logic signed [qte_pkg::DATA_W-1:0]    in_x,
   output logic signed [qte_pkg::ANGLE_W-1:0]   angle,
   output logic signed [qte_pkg::DATA_W-1:0]    mag
);
   import qte_pkg::*;

   cordic_lane_type pre_ff, pre_in;
   cordic_lane_type lane [CORDIC_STAGES+1];

   // left half plane: rotate by +-pi/2 first; both zero flags a zero angle
   always_comb begin
      pre_in.x    = in_x;
      pre_in.y    = in_y;
      pre_in.z    = '0;
      pre_in.zero = (in_x == '0) && (in_y == '0);
      if (in_x[DATA_W-1]) begin
         if (!in_y[DATA_W-1]) begin
            pre_in.x = in_y;
            pre_in.y = -in_x;
            pre_in.z = HALF_PI_Q32;
         end else begin
            pre_in.x = -in_y;
            pre_in.y = in_x;
            pre_in.z = -HALF_PI_Q32;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) pre_ff <= pre_in;
   end

   assign lane[0] = pre_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      qte_cordic_cell u_cell (
         .clock     (clock),
         .enable    (enable),
         .stage_idx (STAGE_IDX_W'(i)),
         .lane_i    (lane[i]),
         .lane_o    (lane[i+1])
      );
   end

   assign angle = lane[CORDIC_STAGES].zero ? '0 : lane[CORDIC_STAGES].z;
   assign mag   = lane[CORDIC_STAGES].x;

endmodule

// File: sv/quaternion_to_euler_attitude.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_attitude: ZYX Euler angles from a Q2.30 quaternion
// Direction-cosine terms, three pipelined CORDIC atan2 chains, output skid.
// ----------------------------------------------------------------------------
// Takes one quaternion word per cycle while req_tready is high and returns roll,
// pitch and yaw in Q3.29 radians, one result word per input word, in order.
// The path is fully pipelined: one word per clock sustained while the output
// buffer has room. The longest path is the roll chain feeding the pitch chain
// through the inverse-gain scaling. A two-entry output buffer keeps input
// accepted while a result waits; req_tready drops only once both entries
// are full. No normalization is done; atan2(0,0) returns 0.
// ----------------------------------------------------------------------------
module quaternion_to_euler_attitude (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // quat_w, quat_x, quat_y, quat_z (32 b each)
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata    // roll_angle 32, pitch_angle 31, yaw_angle 32, pad 1
);
   import qte_pkg::*;

   // pipeline advance: hold everything only when the skid entry is occupied
   logic enable;
   logic [TOTAL_LAT-1:0] vld_ff, vld_in;

   // stage 0: raw products
   logic signed [63:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [63:0] xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic signed [31:0] qw, qx, qy, qz;

   // stage 1: direction-cosine terms
   logic signed [DATA_W-1:0] c11_ff, c21_ff, c31_ff, c32_ff, c33_ff;
   logic signed [DATA_W-1:0] c11_in, c21_in, c31_in, c32_in, c33_in;

   // chain outputs
   logic signed [ANGLE_W-1:0] roll_z, yaw_z, pitch_z;
   logic signed [DATA_W-1:0]  roll_mag, yaw_mag_unused, pitch_mag_unused;

   // delay lines
   logic signed [DATA_W-1:0]  c31_dly_ff [CHAIN_LAT];
   logic signed [ANGLE_W-1:0] roll_dly_ff [CHAIN_LAT+2];
   logic signed [ANGLE_W-1:0] yaw_dly_ff  [CHAIN_LAT+2];

   // inverse-gain scaling, two stages
   logic [63:0]              mag_pos;
   logic [63:0]              ghi_ff, glo_ff;
   logic signed [DATA_W-1:0] ny_a_ff, ny_b_ff, r_ff;

   // output buffer
   rsp_word_type out_ff, skid_ff, res_word;
   logic         out_vld_ff, skid_vld_ff;
   logic signed [32:0] roll_s, pitch_s, yaw_s;

   assign enable     = !skid_vld_ff;
   assign req_tready = enable;

   assign qw = req_tdata[31:0];
   assign qx = req_tdata[63:32];
   assign qy = req_tdata[95:64];
   assign qz = req_tdata[127:96];

   always_ff @(posedge clock) begin
      if (enable) begin
         ww_ff <= qw * qw;  xx_ff <= qx * qx;
         yy_ff <= qy * qy;  zz_ff <= qz * qz;
         xy_ff <= qx * qy;  wz_ff <= qw * qz;
         xz_ff <= qx * qz;  wy_ff <= qw * qy;
         yz_ff <= qy * qz;  wx_ff <= qw * qx;
      end
   end

   // products to Q4.56 with floor, then the cosine sums
   always_comb begin
      c11_in = (ww_ff >>> 4) + (xx_ff >>> 4) - (yy_ff >>> 4) - (zz_ff >>> 4);
      c33_in = (ww_ff >>> 4) - (xx_ff >>> 4) - (yy_ff >>> 4) + (zz_ff >>> 4);
      c21_in = ((xy_ff >>> 4) + (wz_ff >>> 4)) <<< 1;
      c31_in = ((xz_ff >>> 4) - (wy_ff >>> 4)) <<< 1;
      c32_in = ((yz_ff >>> 4) + (wx_ff >>> 4)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         c11_ff <= c11_in;  c21_ff <= c21_in;  c31_ff <= c31_in;
         c32_ff <= c32_in;  c33_ff <= c33_in;
      end
   end

   qte_cordic_chain u_roll (
      .clock (clock), .enable (enable),
      .in_y  (c32_ff), .in_x (c33_ff),
      .angle (roll_z), .mag  (roll_mag)
   );

   qte_cordic_chain u_yaw (
      .clock (clock), .enable (enable),
      .in_y  (c21_ff), .in_x (c11_ff),
      .angle (yaw_z),  .mag  (yaw_mag_unused)
   );

   // magnitude scaled by 1/K: 64 x 32 split into two 32 x 32 halves
   assign mag_pos = (!roll_mag[DATA_W-1] && roll_mag != '0) ? roll_mag : '0;

   always_ff @(posedge clock) begin
      if (enable) begin
         c31_dly_ff[0] <= c31_ff;
         for (int k = 1; k < CHAIN_LAT; k++) c31_dly_ff[k] <= c31_dly_ff[k-1];
         roll_dly_ff[0] <= roll_z;
         yaw_dly_ff[0]  <= yaw_z;
         for (int k = 1; k < CHAIN_LAT + 2; k++) begin
            roll_dly_ff[k] <= roll_dly_ff[k-1];
            yaw_dly_ff[k]  <= yaw_dly_ff[k-1];
         end
         ghi_ff  <= mag_pos[63:32] * INV_GAIN_Q32;
         glo_ff  <= mag_pos[31:0] * INV_GAIN_Q32;
         ny_a_ff <= -c31_dly_ff[CHAIN_LAT-1];
         r_ff    <= $signed(ghi_ff + (glo_ff >> 32));
         ny_b_ff <= ny_a_ff;
      end
   end

   qte_cordic_chain u_pitch (
      .clock (clock), .enable (enable),
      .in_y  (ny_b_ff), .in_x (r_ff),
      .angle (pitch_z), .mag  (pitch_mag_unused)
   );

   always_comb begin
      roll_s         = sat_angle(roll_dly_ff[CHAIN_LAT+1], ROLL_MAX);
      pitch_s        = sat_angle(pitch_z, PITCH_MAX);
      yaw_s          = sat_angle(yaw_dly_ff[CHAIN_LAT+1], ROLL_MAX);
      res_word.roll  = roll_s[31:0];
      res_word.pitch = pitch_s[30:0];
      res_word.yaw   = yaw_s[31:0];
   end

   // valid token shifts with the data
   assign vld_in = {vld_ff[TOTAL_LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_tready) begin
            out_ff      <= skid_ff;
            skid_vld_ff <= 1'b0;
         end
      end else begin
         vld_ff <= vld_in;
         if (!out_vld_ff || rsp_tready) begin
            out_vld_ff <= vld_ff[TOTAL_LAT-1];
            out_ff     <= res_word;
         end else if (vld_ff[TOTAL_LAT-1]) begin
            skid_ff     <= res_word;
            skid_vld_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_ff};

   // skid entry is only filled behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid word without output word");

   // an accepted word enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted word lost at pipeline entry");

   // pipeline holds while the skid entry is full
   a_hold_on_full: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> $stable(vld_ff))
      else $error("pipeline advanced with skid full");

   // pitch stays within half pi
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed({out_ff.pitch[30], out_ff.pitch[30], out_ff.pitch}) <= PITCH_MAX
                      && $signed({out_ff.pitch[30], out_ff.pitch[30], out_ff.pitch}) >= -PITCH_MAX))
      else $error("pitch out of range");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: quaternion_to_euler_attitude
// Drives quaternion words, predicts roll/pitch/yaw with a bit-exact CORDIC
// model and checks every result word in order under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import qte_pkg::*;

   localparam int    STAGES    = 30;
   localparam int    LATENCY   = 66;
   localparam longint HALF_PI  = 64'sd6746518852;
   localparam longint INV_GAIN = 64'sd2608131496;
   localparam longint ANG_MAX  = 64'sd1686629714;
   localparam longint HALF_MAX = 64'sd843314857;
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

   typedef struct packed {
      logic signed [31:0] roll;
      logic signed [30:0] pitch;
      logic signed [31:0] yaw;
   } attitude_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [127:0]  req_tdata;   // quat_w, quat_x, quat_y, quat_z
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [95:0]   rsp_tdata;   // roll 32, pitch 31, yaw 32, pad 1

   attitude_type attitude_q[$];
   int           fail_count;
   bit           calm;         // no idling on either side while set

   quaternion_to_euler_attitude dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Test completed with failures");
      $finish;
   end

   // arithmetic shift right, floor
   function automatic longint asr(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint atan_entry(input int i);
      longint t[11] = '{64'sd3373259426, 64'sd1991351318, 64'sd1052175346,
                        64'sd534100635, 64'sd268086748, 64'sd134174063,
                        64'sd67103403, 64'sd33553749, 64'sd16777131,
                        64'sd8388597, 64'sd4194303};
      if (i < 11) return t[i];
      if (i <= 32) return 64'sd1 <<< (32 - i);
      return 0;
   endfunction

   // vectoring CORDIC; angle in 2^-32 rad, magnitude through mag
   function automatic longint vector_angle(input longint yi, input longint xi,
                                           output longint mag);
      longint x, y, z, t, dx, dy;
      x = xi; y = yi; z = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         return 0;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = HALF_PI;
         end else begin
            x = -y; y = t; z = -HALF_PI;
         end
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = asr(x, i);
         dy = asr(y, i);
         if (y >= 0) begin
            x += dy; y -= dx; z += atan_entry(i);
         end else begin
            x -= dy; y += dx; z -= atan_entry(i);
         end
      end
      mag = x;
      return z;
   endfunction

   function automatic longint round_clamp(input longint acc, input longint lim);
      longint v;
      v = asr(acc + 4, 3);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v;
   endfunction

   function automatic attitude_type predict_attitude(input logic [127:0] q);
      longint w, x, y, z, ww, xx, yy, zz, c11, c21, c31, c32, c33;
      longint mag, unused, r, hi, lo, rl, pt, yw;
      attitude_type a;
      w = longint'($signed(q[31:0]));
      x = longint'($signed(q[63:32]));
      y = longint'($signed(q[95:64]));
      z = longint'($signed(q[127:96]));
      ww = asr(w * w, 4); xx = asr(x * x, 4);
      yy = asr(y * y, 4); zz = asr(z * z, 4);
      c11 = ww + xx - yy - zz;
      c33 = ww - xx - yy + zz;
      c21 = 2 * (asr(x * y, 4) + asr(w * z, 4));
      c31 = 2 * (asr(x * z, 4) - asr(w * y, 4));
      c32 = 2 * (asr(y * z, 4) + asr(w * x, 4));
      rl = vector_angle(c32, c33, mag);
      // inverse CORDIC gain, split so the product fits 64 bits unsigned
      if (mag < 0) mag = 0;
      hi = mag >>> 32;
      lo = mag & 64'hFFFF_FFFF;
      r = hi * INV_GAIN + longint'((unsigned'(lo) * unsigned'(INV_GAIN)) >> 32);
      pt = vector_angle(-c31, r, unused);
      yw = vector_angle(c21, c11, unused);
      a.roll  = 32'(round_clamp(rl, ANG_MAX));
      a.pitch = 31'(round_clamp(pt, HALF_MAX));
      a.yaw   = 32'(round_clamp(yw, ANG_MAX));
      return a;
   endfunction

   // consumer side: random stalls, in-order compare
   always @(posedge clock) begin
      attitude_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 15);
         if (rsp_tvalid && rsp_tready) begin
            got.roll  = rsp_tdata[31:0];
            got.pitch = rsp_tdata[62:32];
            got.yaw   = rsp_tdata[94:63];
            if (attitude_q.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = attitude_q.pop_front();
               if (got.roll !== want.roll) begin
                  $display("%0t: roll expected %0d actual %0d",
                           $time, want.roll, got.roll);
                  fail_count++;
               end
               if (got.pitch !== want.pitch) begin
                  $display("%0t: pitch expected %0d actual %0d",
                           $time, want.pitch, got.pitch);
                  fail_count++;
               end
               if (got.yaw !== want.yaw) begin
                  $display("%0t: yaw expected %0d actual %0d",
                           $time, want.yaw, got.yaw);
                  fail_count++;
               end
            end
         end
      end
   end

   // one quaternion word; random gaps before it unless calm
   task automatic send_quaternion(input logic signed [31:0] w, x, y, z);
      while (!calm && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x, w};
      attitude_q.push_back(predict_attitude({z, y, x, w}));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic idle_source;
      req_tvalid <= 1'b0;
   endtask

   // extremes, zero operands, unit axes, negative-x rotations
   task automatic test_directed;
      logic signed [31:0] v[6] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1,
                                   ONE_Q30, -ONE_Q30};
      send_quaternion(0, 0, 0, 0);
      send_quaternion(ONE_Q30, 0, 0, 0);
      send_quaternion(-ONE_Q30, 0, 0, 0);
      send_quaternion(0, ONE_Q30, 0, 0);
      send_quaternion(0, 0, ONE_Q30, 0);
      send_quaternion(0, 0, 0, ONE_Q30);
      send_quaternion(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_quaternion(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_quaternion(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      // gimbal lock: pitch at +-90 deg
      send_quaternion(32'sd759250125, 0, 32'sd759250125, 0);
      send_quaternion(32'sd759250125, 0, -32'sd759250125, 0);
      for (int i = 0; i < 12; i++)
         send_quaternion(v[$urandom_range(5)], v[$urandom_range(5)],
                         v[$urandom_range(5)], v[$urandom_range(5)]);
      idle_source();
   endtask

   // mostly scaled-down random quaternions, some full-range noise
   task automatic test_random(input int count);
      logic signed [31:0] c[4];
      int sc;
      for (int n = 0; n < count; n++) begin
         calm = (n >= count / 3 && n < count / 3 + 200);
         if ($urandom_range(3) == 0) begin
            foreach (c[k]) c[k] = $urandom;
         end else begin
            sc = $urandom_range(12);
            foreach (c[k]) c[k] = $signed($urandom) >>> (2 + sc);
         end
         send_quaternion(c[0], c[1], c[2], c[3]);
      end
      calm = 1'b0;
      idle_source();
   endtask

   initial begin
      int guard;
      calm       = 1'b0;
      fail_count = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1500);
      guard = 0;
      while (attitude_q.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && attitude_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
